@@ rtl/bev_pkg.sv @@
// ----------------------------------------------------------------------------
// bev_pkg - shared constants and types for the bearing encirclement core
// Fixed-point formats, derived datapath widths and configuration indexes.
// ----------------------------------------------------------------------------
package bev_pkg;

  // bearing / rotation fraction bits (Q2.14 by default, valid 8..30)
  localparam int FRAC_BITS = 14;
  localparam int GAIN_FRAC = 12;

  localparam int IN_W   = 16;   // bearing components, rotation values
  localparam int GAIN_W = 16;   // unsigned gains
  localparam int OUT_W  = 24;   // velocity outputs
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;

  // pipeline depth: four projection stages, four mixing stages
  localparam int PROJ_STAGES = 4;
  localparam int MIX_STAGES  = 4;
  localparam int NUM_STAGES  = PROJ_STAGES + MIX_STAGES;

  // dot product s.b
  localparam int PROD_W    = 2 * IN_W;
  localparam int DOTSUM_W  = PROD_W + 2;
  localparam int DOT_W     = DOTSUM_W - FRAC_BITS;

  // b*2^F - s*dot
  localparam int MUL_W     = IN_W + DOT_W;
  localparam int SHL_W     = IN_W + FRAC_BITS;
  localparam int OX_W      = ((MUL_W > SHL_W) ? MUL_W : SHL_W) + 1;
  localparam int P_W       = OX_W - FRAC_BITS;

  // gained sum
  localparam int DIFF_W    = P_W + 1;
  localparam int SGAIN_W   = GAIN_W + 1;
  localparam int KD_W      = DIFF_W + SGAIN_W;
  localparam int USUM_W    = KD_W + 1;
  localparam int U_W       = USUM_W - GAIN_FRAC;

  // rotation
  localparam int ROT_W     = IN_W + U_W;
  localparam int RSUM_W    = ROT_W + 1;
  localparam int R_W       = RSUM_W - FRAC_BITS;
  localparam int SAT_W     = (R_W > OUT_W) ? R_W : OUT_W + 1;

  // round-half-up offsets
  localparam logic signed [DOTSUM_W-1:0] DOT_HALF = DOTSUM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [OX_W-1:0]     OX_HALF  = OX_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [USUM_W-1:0]   U_HALF   = USUM_W'(1) <<< (GAIN_FRAC - 1);
  localparam logic signed [RSUM_W-1:0]   R_HALF   = RSUM_W'(1) <<< (FRAC_BITS - 1);

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEIGHBOUR_GAIN = 2'd0,
    CFG_TARGET_GAIN    = 2'd1,
    CFG_ROT_COS        = 2'd2,
    CFG_ROT_SIN        = 2'd3
  } cfg_idx_t;

  localparam logic [GAIN_W-1:0]      RST_NEIGHBOUR_GAIN = 16'd20480;
  localparam logic [GAIN_W-1:0]      RST_TARGET_GAIN    = 16'd20480;
  localparam logic signed [IN_W-1:0] RST_ROT_COS        = 16'sd16384;
  localparam logic signed [IN_W-1:0] RST_ROT_SIN        = 16'sd0;

  // stage advance enables, front stage first
  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } stage_ctl_t;

endpackage

@@ rtl/bev_ctl.sv @@
// ----------------------------------------------------------------------------
// bev_ctl - pipeline valid tracking and stall propagation
// One valid bit per stage; a stage advances when empty or when its successor
// advances, so bubbles collapse under a stalled output.
// ----------------------------------------------------------------------------
module bev_ctl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              out_stall,
  output bev_pkg::stage_ctl_t               ctl,
  output logic [bev_pkg::NUM_STAGES-1:0]    valid,
  output logic                              in_stall,
  output logic                              out_valid
);

  logic [bev_pkg::NUM_STAGES-1:0] valid_r;
  logic [bev_pkg::NUM_STAGES-1:0] valid_nxt;
  logic [bev_pkg::NUM_STAGES-1:0] en;

  always_comb begin
    en[bev_pkg::NUM_STAGES-1] = !valid_r[bev_pkg::NUM_STAGES-1] || !out_stall;
    for (int k = bev_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
    valid_nxt = valid_r;
    for (int k = 0; k < bev_pkg::NUM_STAGES; k++) begin
      if (en[k]) begin
        valid_nxt[k] = (k == 0) ? in_valid : valid_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign ctl.en    = en;
  assign valid     = valid_r;
  assign in_stall  = !en[0];
  assign out_valid = valid_r[bev_pkg::NUM_STAGES-1];

endmodule

@@ rtl/bev_proj.sv @@
// ----------------------------------------------------------------------------
// bev_proj - four-stage projection P(s,b) = b - s*(s.b)
// Products, rounded dot, s*dot products, rounded difference.
// ----------------------------------------------------------------------------
module bev_proj (
  input  logic                                   clk,
  input  logic [bev_pkg::PROJ_STAGES-1:0]        en,
  input  logic signed [bev_pkg::IN_W-1:0]        sx,
  input  logic signed [bev_pkg::IN_W-1:0]        sy,
  input  logic signed [bev_pkg::IN_W-1:0]        bx,
  input  logic signed [bev_pkg::IN_W-1:0]        by,
  output logic signed [bev_pkg::P_W-1:0]         px,
  output logic signed [bev_pkg::P_W-1:0]         py
);

  // stage 0: s.b partial products
  logic signed [bev_pkg::PROD_W-1:0] pxx_r, pyy_r;
  logic signed [bev_pkg::IN_W-1:0]   sx0_r, sy0_r, bx0_r, by0_r;
  // stage 1: rounded dot
  logic signed [bev_pkg::DOTSUM_W-1:0] dot_sum;
  logic signed [bev_pkg::DOT_W-1:0]    dot_r;
  logic signed [bev_pkg::IN_W-1:0]     sx1_r, sy1_r, bx1_r, by1_r;
  // stage 2: s*dot
  logic signed [bev_pkg::MUL_W-1:0]    mx_r, my_r;
  logic signed [bev_pkg::IN_W-1:0]     bx2_r, by2_r;
  // stage 3: rounded b*2^F - s*dot
  logic signed [bev_pkg::OX_W-1:0]     ox, oy;
  logic signed [bev_pkg::P_W-1:0]      px_r, py_r;

  assign dot_sum = bev_pkg::DOTSUM_W'(pxx_r) + bev_pkg::DOTSUM_W'(pyy_r) + bev_pkg::DOT_HALF;

  assign ox = (bev_pkg::OX_W'(bx2_r) <<< bev_pkg::FRAC_BITS) - bev_pkg::OX_W'(mx_r)
              + bev_pkg::OX_HALF;
  assign oy = (bev_pkg::OX_W'(by2_r) <<< bev_pkg::FRAC_BITS) - bev_pkg::OX_W'(my_r)
              + bev_pkg::OX_HALF;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pxx_r <= bev_pkg::PROD_W'(sx) * bev_pkg::PROD_W'(bx);
      pyy_r <= bev_pkg::PROD_W'(sy) * bev_pkg::PROD_W'(by);
      sx0_r <= sx;
      sy0_r <= sy;
      bx0_r <= bx;
      by0_r <= by;
    end
    if (en[1]) begin
      dot_r <= dot_sum[bev_pkg::DOTSUM_W-1 -: bev_pkg::DOT_W];
      sx1_r <= sx0_r;
      sy1_r <= sy0_r;
      bx1_r <= bx0_r;
      by1_r <= by0_r;
    end
    if (en[2]) begin
      mx_r  <= bev_pkg::MUL_W'(sx1_r) * bev_pkg::MUL_W'(dot_r);
      my_r  <= bev_pkg::MUL_W'(sy1_r) * bev_pkg::MUL_W'(dot_r);
      bx2_r <= bx1_r;
      by2_r <= by1_r;
    end
    if (en[3]) begin
      px_r <= ox[bev_pkg::OX_W-1 -: bev_pkg::P_W];
      py_r <= oy[bev_pkg::OX_W-1 -: bev_pkg::P_W];
    end
  end

  assign px = px_r;
  assign py = py_r;

endmodule

@@ rtl/bev_mix.sv @@
// ----------------------------------------------------------------------------
// bev_mix - four-stage gain, rotation and saturation
// Gain products, rounded sum, rotation products, rounded saturated output.
// ----------------------------------------------------------------------------
module bev_mix (
  input  logic                                 clk,
  input  logic [bev_pkg::MIX_STAGES-1:0]       en,
  input  logic [bev_pkg::GAIN_W-1:0]           neighbour_gain,
  input  logic [bev_pkg::GAIN_W-1:0]           target_gain,
  input  logic signed [bev_pkg::IN_W-1:0]      rot_cos,
  input  logic signed [bev_pkg::IN_W-1:0]      rot_sin,
  input  logic signed [bev_pkg::P_W-1:0]       nx,
  input  logic signed [bev_pkg::P_W-1:0]       ny,
  input  logic signed [bev_pkg::P_W-1:0]       px,
  input  logic signed [bev_pkg::P_W-1:0]       py,
  input  logic signed [bev_pkg::P_W-1:0]       tx,
  input  logic signed [bev_pkg::P_W-1:0]       ty,
  output logic signed [bev_pkg::OUT_W-1:0]     vel_x,
  output logic signed [bev_pkg::OUT_W-1:0]     vel_y
);

  logic signed [bev_pkg::SGAIN_W-1:0] ka, kb;
  logic signed [bev_pkg::DIFF_W-1:0]  dx, dy;
  logic signed [bev_pkg::KD_W-1:0]    kdx_r, kdy_r, ktx_r, kty_r;
  logic signed [bev_pkg::USUM_W-1:0]  usum_x, usum_y;
  logic signed [bev_pkg::U_W-1:0]     ux_r, uy_r;
  logic signed [bev_pkg::ROT_W-1:0]   cux_r, suy_r, sux_r, cuy_r;
  logic signed [bev_pkg::RSUM_W-1:0]  rsum_x, rsum_y;
  logic signed [bev_pkg::SAT_W-1:0]   rx, ry;
  logic signed [bev_pkg::OUT_W-1:0]   vx_nxt, vy_nxt, vx_r, vy_r;

  function automatic logic signed [bev_pkg::OUT_W-1:0] sat(
    input logic signed [bev_pkg::SAT_W-1:0] v
  );
    logic signed [bev_pkg::OUT_W-1:0] res;
    if (v > bev_pkg::SAT_W'(bev_pkg::OUT_MAX)) begin
      res = bev_pkg::OUT_MAX;
    end else if (v < bev_pkg::SAT_W'(bev_pkg::OUT_MIN)) begin
      res = bev_pkg::OUT_MIN;
    end else begin
      res = v[bev_pkg::OUT_W-1:0];
    end
    return res;
  endfunction

  assign ka = $signed({1'b0, neighbour_gain});
  assign kb = $signed({1'b0, target_gain});
  assign dx = bev_pkg::DIFF_W'(px) - bev_pkg::DIFF_W'(nx);
  assign dy = bev_pkg::DIFF_W'(py) - bev_pkg::DIFF_W'(ny);

  assign usum_x = bev_pkg::USUM_W'(kdx_r) - bev_pkg::USUM_W'(ktx_r) + bev_pkg::U_HALF;
  assign usum_y = bev_pkg::USUM_W'(kdy_r) - bev_pkg::USUM_W'(kty_r) + bev_pkg::U_HALF;

  assign rsum_x = bev_pkg::RSUM_W'(cux_r) - bev_pkg::RSUM_W'(suy_r) + bev_pkg::R_HALF;
  assign rsum_y = bev_pkg::RSUM_W'(sux_r) + bev_pkg::RSUM_W'(cuy_r) + bev_pkg::R_HALF;
  assign rx     = bev_pkg::SAT_W'(rsum_x[bev_pkg::RSUM_W-1 -: bev_pkg::R_W]);
  assign ry     = bev_pkg::SAT_W'(rsum_y[bev_pkg::RSUM_W-1 -: bev_pkg::R_W]);
  assign vx_nxt = sat(rx);
  assign vy_nxt = sat(ry);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      kdx_r <= bev_pkg::KD_W'(ka) * bev_pkg::KD_W'(dx);
      kdy_r <= bev_pkg::KD_W'(ka) * bev_pkg::KD_W'(dy);
      ktx_r <= bev_pkg::KD_W'(kb) * bev_pkg::KD_W'(tx);
      kty_r <= bev_pkg::KD_W'(kb) * bev_pkg::KD_W'(ty);
    end
    if (en[1]) begin
      ux_r <= usum_x[bev_pkg::USUM_W-1 -: bev_pkg::U_W];
      uy_r <= usum_y[bev_pkg::USUM_W-1 -: bev_pkg::U_W];
    end
    if (en[2]) begin
      cux_r <= bev_pkg::ROT_W'(rot_cos) * bev_pkg::ROT_W'(ux_r);
      suy_r <= bev_pkg::ROT_W'(rot_sin) * bev_pkg::ROT_W'(uy_r);
      sux_r <= bev_pkg::ROT_W'(rot_sin) * bev_pkg::ROT_W'(ux_r);
      cuy_r <= bev_pkg::ROT_W'(rot_cos) * bev_pkg::ROT_W'(uy_r);
    end
    if (en[3]) begin
      vx_r <= vx_nxt;
      vy_r <= vy_nxt;
    end
  end

  assign vel_x = vx_r;
  assign vel_y = vy_r;

endmodule

@@ rtl/bearing_encirclement_velocity_law_core.sv @@
// ----------------------------------------------------------------------------
// bearing_encirclement_velocity_law_core - bearing-only encirclement law
// Forms k_n*(P(prev)-P(next)) - k_t*P(tgt) from unit bearings and rotates it.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one item carries the measured and
//    desired bearings to next neighbour, previous neighbour and target, all
//    signed Q2.14. An item is taken on a clock edge with valid high, stall low.
//  - Output channel (out_valid / out_stall): one item per input item, the
//    rotated velocity x/y in signed Q10.14, saturated to 24 bits.
//  - Config port (cfg_we / cfg_index / cfg_data): gains (unsigned Q4.12) and
//    rotation cosine/sine (signed Q2.14). Write only while the core is idle.
//  - Pipeline: one register stage per multiplier or rounding adder between
//    acceptance and out_valid (4 for the projections, 4 for gain/rotate).
//  - Throughput: one item per cycle unless in_stall is high; all stages are fully pipelined.
//  - Stall: a stalled output holds its item; upstream stages keep filling
//    bubbles, and in_stall rises only once all eight stages are occupied.
//  - Reset (rst_n low, synchronous): pipeline emptied, registers return to
//    gains 5.0, cosine 1.0, sine 0.
// ----------------------------------------------------------------------------
module bearing_encirclement_velocity_law_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [bev_pkg::IN_W-1:0]        in_next_meas_x,
  input  logic signed [bev_pkg::IN_W-1:0]        in_next_meas_y,
  input  logic signed [bev_pkg::IN_W-1:0]        in_prev_meas_x,
  input  logic signed [bev_pkg::IN_W-1:0]        in_prev_meas_y,
  input  logic signed [bev_pkg::IN_W-1:0]        in_tgt_meas_x,
  input  logic signed [bev_pkg::IN_W-1:0]        in_tgt_meas_y,
  input  logic signed [bev_pkg::IN_W-1:0]        in_next_want_x,
  input  logic signed [bev_pkg::IN_W-1:0]        in_next_want_y,
  input  logic signed [bev_pkg::IN_W-1:0]        in_prev_want_x,
  input  logic signed [bev_pkg::IN_W-1:0]        in_prev_want_y,
  input  logic signed [bev_pkg::IN_W-1:0]        in_tgt_want_x,
  input  logic signed [bev_pkg::IN_W-1:0]        in_tgt_want_y,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [bev_pkg::OUT_W-1:0]       out_velocity_x,
  output logic signed [bev_pkg::OUT_W-1:0]       out_velocity_y,
  // configuration
  input  logic                                   cfg_we,
  input  logic [bev_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [bev_pkg::CFG_W-1:0]              cfg_data
);

  bev_pkg::stage_ctl_t              ctl;
  logic [bev_pkg::NUM_STAGES-1:0]   valid;

  logic [bev_pkg::GAIN_W-1:0]       neighbour_gain_r, target_gain_r;
  logic signed [bev_pkg::IN_W-1:0]  rot_cos_r, rot_sin_r;

  logic signed [bev_pkg::P_W-1:0]   nx, ny, px, py, tx, ty;

  // --- configuration registers ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neighbour_gain_r <= bev_pkg::RST_NEIGHBOUR_GAIN;
      target_gain_r    <= bev_pkg::RST_TARGET_GAIN;
      rot_cos_r        <= bev_pkg::RST_ROT_COS;
      rot_sin_r        <= bev_pkg::RST_ROT_SIN;
    end else if (cfg_we) begin
      unique case (bev_pkg::cfg_idx_t'(cfg_index))
        bev_pkg::CFG_NEIGHBOUR_GAIN: neighbour_gain_r <= cfg_data;
        bev_pkg::CFG_TARGET_GAIN:    target_gain_r    <= cfg_data;
        bev_pkg::CFG_ROT_COS:        rot_cos_r        <= $signed(cfg_data);
        bev_pkg::CFG_ROT_SIN:        rot_sin_r        <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // --- handshake and stage valids ---
  bev_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .valid     (valid),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // --- three projections in parallel (stages 0..3) ---
  bev_proj u_proj_next (
    .clk (clk),
    .en  (ctl.en[bev_pkg::PROJ_STAGES-1:0]),
    .sx  (in_next_want_x),
    .sy  (in_next_want_y),
    .bx  (in_next_meas_x),
    .by  (in_next_meas_y),
    .px  (nx),
    .py  (ny)
  );

  bev_proj u_proj_prev (
    .clk (clk),
    .en  (ctl.en[bev_pkg::PROJ_STAGES-1:0]),
    .sx  (in_prev_want_x),
    .sy  (in_prev_want_y),
    .bx  (in_prev_meas_x),
    .by  (in_prev_meas_y),
    .px  (px),
    .py  (py)
  );

  bev_proj u_proj_tgt (
    .clk (clk),
    .en  (ctl.en[bev_pkg::PROJ_STAGES-1:0]),
    .sx  (in_tgt_want_x),
    .sy  (in_tgt_want_y),
    .bx  (in_tgt_meas_x),
    .by  (in_tgt_meas_y),
    .px  (tx),
    .py  (ty)
  );

  // --- gains, rotation, saturation (stages 4..7) ---
  bev_mix u_mix (
    .clk            (clk),
    .en             (ctl.en[bev_pkg::NUM_STAGES-1:bev_pkg::PROJ_STAGES]),
    .neighbour_gain (neighbour_gain_r),
    .target_gain    (target_gain_r),
    .rot_cos        (rot_cos_r),
    .rot_sin        (rot_sin_r),
    .nx             (nx),
    .ny             (ny),
    .px             (px),
    .py             (py),
    .tx             (tx),
    .ty             (ty),
    .vel_x          (out_velocity_x),
    .vel_y          (out_velocity_y)
  );

  // --- checks ---
  // input back-pressure only once every stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&valid))
    else $error("in_stall raised with a free pipeline stage");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set straight after reset");

  // a delivered item with nothing behind it leaves the output empty
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !valid[bev_pkg::NUM_STAGES-2]) |=> !out_valid)
    else $error("output item repeated");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for bearing_encirclement_velocity_law_core
// Sends bearing sets under several gain and rotation settings, with random
// gaps on both channels and one long output hold. Each result is checked
// against a bit-exact fixed-point prediction of the encirclement law.
// ----------------------------------------------------------------------------
module testbench;

  localparam int HALF_PERIOD      = 6;
  localparam int RESET_CYCLES     = 7;
  localparam int MAX_GAP          = 14;
  localparam int LONG_HOLD_CYCLES = 64;
  localparam int RANDOM_PHASES    = 8;
  localparam int ITEMS_PER_PHASE  = 235;
  localparam int PRESSURE_ITEMS   = 40;
  localparam int CORNER_SETS      = 8;

  typedef logic signed [bev_pkg::IN_W-1:0] comp_t;

  // One item: field order matches the port list, x above y in each pair,
  // so every 32-bit slice is one bearing.
  typedef struct packed {
    comp_t next_meas_x;
    comp_t next_meas_y;
    comp_t prev_meas_x;
    comp_t prev_meas_y;
    comp_t tgt_meas_x;
    comp_t tgt_meas_y;
    comp_t next_want_x;
    comp_t next_want_y;
    comp_t prev_want_x;
    comp_t prev_want_y;
    comp_t tgt_want_x;
    comp_t tgt_want_y;
  } bearing_set_t;

  typedef struct packed {
    logic signed [bev_pkg::OUT_W-1:0] velocity_x;
    logic signed [bev_pkg::OUT_W-1:0] velocity_y;
  } velocity_t;

  typedef enum {COMP_RAW, COMP_NEAR, COMP_EXTREME} comp_kind_t;

  localparam comp_t ZERO     = 16'sd0;
  localparam comp_t ONE      = 16'sd16384;   // 1.0 in Q2.14
  localparam comp_t NEG_ONE  = -16'sd16384;
  localparam comp_t DIAG     = 16'sd11585;   // ~cos(45 deg)
  localparam comp_t NEG_DIAG = -16'sd11585;
  localparam comp_t HALF_LSB = 16'sd8192;    // half of one Q2.14 step times 2^14
  localparam comp_t LSB      = 16'sd1;
  localparam comp_t MAX_C    = 16'sh7FFF;
  localparam comp_t MIN_C    = 16'sh8000;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic  in_valid = 1'b0;
  logic  in_stall;
  comp_t in_next_meas_x = '0;
  comp_t in_next_meas_y = '0;
  comp_t in_prev_meas_x = '0;
  comp_t in_prev_meas_y = '0;
  comp_t in_tgt_meas_x  = '0;
  comp_t in_tgt_meas_y  = '0;
  comp_t in_next_want_x = '0;
  comp_t in_next_want_y = '0;
  comp_t in_prev_want_x = '0;
  comp_t in_prev_want_y = '0;
  comp_t in_tgt_want_x  = '0;
  comp_t in_tgt_want_y  = '0;

  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [bev_pkg::OUT_W-1:0] out_velocity_x;
  logic signed [bev_pkg::OUT_W-1:0] out_velocity_y;

  logic                      cfg_we    = 1'b0;
  bev_pkg::cfg_idx_t         cfg_index = bev_pkg::CFG_NEIGHBOUR_GAIN;
  logic [bev_pkg::CFG_W-1:0] cfg_data  = '0;

  bearing_encirclement_velocity_law_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_next_meas_x (in_next_meas_x),
    .in_next_meas_y (in_next_meas_y),
    .in_prev_meas_x (in_prev_meas_x),
    .in_prev_meas_y (in_prev_meas_y),
    .in_tgt_meas_x  (in_tgt_meas_x),
    .in_tgt_meas_y  (in_tgt_meas_y),
    .in_next_want_x (in_next_want_x),
    .in_next_want_y (in_next_want_y),
    .in_prev_want_x (in_prev_want_x),
    .in_prev_want_y (in_prev_want_y),
    .in_tgt_want_x  (in_tgt_want_x),
    .in_tgt_want_y  (in_tgt_want_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_velocity_x (out_velocity_x),
    .out_velocity_y (out_velocity_y),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  // Shadow of the four registers, at their reset values until written.
  logic [bev_pkg::GAIN_W-1:0] neighbour_gain_q = 16'd20480;
  logic [bev_pkg::GAIN_W-1:0] target_gain_q    = 16'd20480;
  comp_t                      rot_cos_q        = 16'sd16384;
  comp_t                      rot_sin_q        = 16'sd0;

  velocity_t expected_velocity_q[$];   // one entry per accepted item, oldest first
  int        mismatch_count = 0;

  bit sender_idles   = 1'b1;   // random gaps before each item
  bit receiver_idles = 1'b1;   // random stall before each result
  bit hold_results   = 1'b0;   // request for one long output hold

  // --------------------------------------------------------------------------
  // Velocity law prediction
  // --------------------------------------------------------------------------
  // floor(x / 2^n + 1/2): arithmetic shift of a signed longint is a floor
  function automatic longint round_half_up(input longint x, input int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  // P(s,b) = b - s*(s.b), result at FRAC_BITS fraction bits
  function automatic void project_bearing(input longint sx, input longint sy,
                                          input longint bx, input longint by,
                                          output longint px, output longint py);
    longint dot;
    dot = round_half_up(sx * bx + sy * by, bev_pkg::FRAC_BITS);
    px  = round_half_up((bx <<< bev_pkg::FRAC_BITS) - sx * dot, bev_pkg::FRAC_BITS);
    py  = round_half_up((by <<< bev_pkg::FRAC_BITS) - sy * dot, bev_pkg::FRAC_BITS);
  endfunction

  function automatic logic signed [bev_pkg::OUT_W-1:0] clamp_velocity(input longint v);
    longint hi = (longint'(1) <<< (bev_pkg::OUT_W - 1)) - 1;
    longint lo = -(longint'(1) <<< (bev_pkg::OUT_W - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[bev_pkg::OUT_W-1:0];
  endfunction

  function automatic velocity_t predict_velocity(input bearing_set_t b);
    longint nx, ny, px, py, tx, ty, ux, uy, kn, kt, c, s;
    velocity_t v;
    kn = neighbour_gain_q;   // unsigned gains zero-extend
    kt = target_gain_q;
    c  = rot_cos_q;          // rotation values sign-extend
    s  = rot_sin_q;
    project_bearing(b.next_want_x, b.next_want_y, b.next_meas_x, b.next_meas_y, nx, ny);
    project_bearing(b.prev_want_x, b.prev_want_y, b.prev_meas_x, b.prev_meas_y, px, py);
    project_bearing(b.tgt_want_x, b.tgt_want_y, b.tgt_meas_x, b.tgt_meas_y, tx, ty);
    ux = round_half_up(kn * (px - nx) - kt * tx, bev_pkg::GAIN_FRAC);
    uy = round_half_up(kn * (py - ny) - kt * ty, bev_pkg::GAIN_FRAC);
    v.velocity_x = clamp_velocity(round_half_up(c * ux - s * uy, bev_pkg::FRAC_BITS));
    v.velocity_y = clamp_velocity(round_half_up(s * ux + c * uy, bev_pkg::FRAC_BITS));
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------
  // unit bearing at a random angle, returned as {x, y}
  function automatic logic [2*bev_pkg::IN_W-1:0] unit_pair();
    real a;
    comp_t x, y;
    a = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
    x = comp_t'($rtoi($cos(a) * 16384.0));
    y = comp_t'($rtoi($sin(a) * 16384.0));
    return {x, y};
  endfunction

  function automatic comp_t draw_component(input comp_kind_t kind);
    unique case (kind)
      COMP_RAW:  return comp_t'($urandom);
      COMP_NEAR: return comp_t'($urandom_range(0, 32768) - 16384);
      default: begin
        unique case ($urandom_range(0, 7))
          0:       return MIN_C;
          1:       return MIN_C + LSB;
          2:       return NEG_ONE;
          3:       return -LSB;
          4:       return ZERO;
          5:       return LSB;
          6:       return ONE;
          default: return MAX_C;
        endcase
      end
    endcase
  endfunction

  // Two in five sets are genuine unit bearings, as a formation would see them; the rest
  // raw 16-bit noise, loose near-unit values and corner values.
  function automatic bearing_set_t random_set();
    bearing_set_t b;
    int         pick;
    comp_kind_t kind;
    pick = $urandom_range(0, 19);
    if (pick < 8) begin
      for (int i = 0; i < 6; i++) b[i*2*bev_pkg::IN_W +: 2*bev_pkg::IN_W] = unit_pair();
    end else begin
      kind = (pick < 15) ? COMP_RAW : (pick < 18) ? COMP_NEAR : COMP_EXTREME;
      for (int i = 0; i < 12; i++) b[i*bev_pkg::IN_W +: bev_pkg::IN_W] = draw_component(kind);
    end
    return b;
  endfunction

  // Hand-picked sets; order is meas next/prev/tgt, then want next/prev/tgt.
  function automatic bearing_set_t corner_set(input int which);
    unique case (which)
      0: return '0;
      1: return {12{MAX_C}};
      2: return {12{MIN_C}};
      // measured equals desired: every projection vanishes
      3: return {ONE, ZERO, ZERO, ONE, NEG_ONE, ZERO,
                 ONE, ZERO, ZERO, ONE, NEG_ONE, ZERO};
      // measured perpendicular to desired: projection is the whole bearing
      4: return {ZERO, ONE, NEG_ONE, ZERO, ZERO, NEG_ONE,
                 ONE, ZERO, ZERO, ONE, ONE, ZERO};
      // non-unit bearings at the limits of the format
      5: return {MAX_C, MIN_C, MIN_C, MAX_C, MIN_C, MIN_C,
                 MIN_C, MAX_C, MAX_C, MAX_C, MAX_C, MIN_C};
      // dot products landing exactly on a half step, both signs
      6: return {HALF_LSB, ZERO, -HALF_LSB, ZERO, ZERO, HALF_LSB,
                 LSB, ZERO, LSB, ZERO, ZERO, -LSB};
      // measured opposite to desired at 45 degrees
      default: return {NEG_DIAG, NEG_DIAG, DIAG, NEG_DIAG, DIAG, DIAG,
                       DIAG, DIAG, NEG_DIAG, DIAG, NEG_DIAG, NEG_DIAG};
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input side: offer one item and hold it until taken. Called on a rising
  // edge; returns on the edge at which the item was accepted, with valid
  // still high so the next item can follow without a bubble.
  // --------------------------------------------------------------------------
  task automatic send_bearing_set(input bearing_set_t b);
    int gap;
    gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_next_meas_x <= b.next_meas_x;
    in_next_meas_y <= b.next_meas_y;
    in_prev_meas_x <= b.prev_meas_x;
    in_prev_meas_y <= b.prev_meas_y;
    in_tgt_meas_x  <= b.tgt_meas_x;
    in_tgt_meas_y  <= b.tgt_meas_y;
    in_next_want_x <= b.next_want_x;
    in_next_want_y <= b.next_want_y;
    in_prev_want_x <= b.prev_want_x;
    in_prev_want_y <= b.prev_want_y;
    in_tgt_want_x  <= b.tgt_want_x;
    in_tgt_want_y  <= b.tgt_want_y;
    // in_stall read here is its value just before the edge
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_velocity_q.push_back(predict_velocity(b));
  endtask

  // Drop valid, let the pipeline drain, then write all four registers on
  // consecutive edges. Every item yields a result, so an empty queue means
  // the core is idle.
  task automatic write_registers(input logic [bev_pkg::GAIN_W-1:0] kn,
                                 input logic [bev_pkg::GAIN_W-1:0] kt,
                                 input comp_t c, input comp_t s);
    in_valid <= 1'b0;
    while (expected_velocity_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= bev_pkg::CFG_NEIGHBOUR_GAIN;
    cfg_data  <= kn;
    @(posedge clk);
    cfg_index <= bev_pkg::CFG_TARGET_GAIN;
    cfg_data  <= kt;
    @(posedge clk);
    cfg_index <= bev_pkg::CFG_ROT_COS;
    cfg_data  <= c;
    @(posedge clk);
    cfg_index <= bev_pkg::CFG_ROT_SIN;
    cfg_data  <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    neighbour_gain_q = kn;
    target_gain_q    = kt;
    rot_cos_q        = c;
    rot_sin_q        = s;
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall before each result, plus one long hold on
  // request. The hold is counted here, independent of the sender.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int wait_cycles;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      wait_cycles = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Result check: sampled on the edge, so DUT outputs and out_stall are
  // their pre-edge values.
  always @(posedge clk) begin : result_check
    velocity_t predicted;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_velocity_q.size() == 0) begin
        $error("result with no item outstanding: x %0d y %0d",
               out_velocity_x, out_velocity_y);
        mismatch_count++;
      end else begin
        predicted = expected_velocity_q.pop_front();
        if (out_velocity_x !== predicted.velocity_x) begin
          $error("velocity_x: expected %0d, got %0d", predicted.velocity_x, out_velocity_x);
          mismatch_count++;
        end
        if (out_velocity_y !== predicted.velocity_y) begin
          $error("velocity_y: expected %0d, got %0d", predicted.velocity_y, out_velocity_y);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Corner sets at the reset settings (gains 5.0, no rotation).
  task automatic test_reset_values();
    for (int i = 0; i < CORNER_SETS; i++) send_bearing_set(corner_set(i));
  endtask

  // Register extremes, including rotation values beyond +-1.0; the largest
  // gains with limit-valued bearings drive both outputs into saturation.
  task automatic test_register_extremes();
    write_registers(16'hFFFF, 16'hFFFF, MIN_C, MAX_C);
    send_bearing_set(corner_set(1));
    send_bearing_set(corner_set(2));
    send_bearing_set(corner_set(5));
    write_registers(16'h0000, 16'h0000, ONE, ZERO);
    send_bearing_set(corner_set(5));
    send_bearing_set(corner_set(6));
    write_registers(16'hFFFF, 16'h0000, NEG_ONE, NEG_ONE);
    send_bearing_set(corner_set(2));
    send_bearing_set(corner_set(5));
    write_registers(16'h0001, 16'hFFFF, MAX_C, MIN_C);
    send_bearing_set(corner_set(5));
    send_bearing_set(corner_set(6));
    send_bearing_set(corner_set(7));
  endtask

  // Random items in phases; each phase has its own settings and one of four mixes
  // of idling, two phases with none on either side.
  task automatic test_random_settings();
    logic [2*bev_pkg::IN_W-1:0] rot;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      unique case (phase)
        0: write_registers(16'd20480, 16'd20480, ONE, ZERO);
        1: write_registers(16'hFFFF, 16'hFFFF, MIN_C, MAX_C);
        2: write_registers(16'd0, 16'd4096, ZERO, ONE);
        3: write_registers(16'd4096, 16'd0, NEG_ONE, ZERO);
        default: begin
          if ($urandom_range(0, 1) == 0) rot = unit_pair();
          else rot = $urandom;
          write_registers(16'($urandom), 16'($urandom),
                          rot[2*bev_pkg::IN_W-1:bev_pkg::IN_W], rot[bev_pkg::IN_W-1:0]);
        end
      endcase
      sender_idles   = (phase % 4 == 0) || (phase % 4 == 2);
      receiver_idles = (phase % 4 == 0) || (phase % 4 == 1);
      repeat (ITEMS_PER_PHASE) send_bearing_set(random_set());
    end
  endtask

  // Long output hold while items keep coming back to back: the pipeline
  // fills and in_stall must rise without losing or reordering anything.
  task automatic test_back_pressure();
    write_registers(16'($urandom), 16'($urandom), DIAG, NEG_DIAG);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    hold_results   = 1'b1;
    repeat (PRESSURE_ITEMS) send_bearing_set(random_set());
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_register_extremes();
    test_random_settings();
    test_back_pressure();
    in_valid <= 1'b0;
    while (expected_velocity_q.size() != 0) @(posedge clk);
    // wait on past the pipeline depth to catch any stray result
    repeat (bev_pkg::NUM_STAGES + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** bearing_encirclement_velocity_law_core: PASSED **");
    end else begin
      $display("** bearing_encirclement_velocity_law_core: FAILED **");
    end
    $finish;
  end

  // Watchdog: ends the run as failed if the sequence does not finish.
  initial begin : watchdog
    #10_000_000;
    $display("** bearing_encirclement_velocity_law_core: FAILED **");
    $finish;
  end

endmodule
